/* sv/mp2d_pkg.sv */
// Shared types, constants and helpers for the 2-D max pooling block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mp2d_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Plane store
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;  // load count saturates at STORE_DEPTH

  // Register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_KERNEL_H = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_W = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_H = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_W = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAD_TOP  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PAD_BOT  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PAD_LEFT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PAD_RGT  = 3'd7;

  // Item codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_FETCH   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef struct packed {
    logic [3:0] kernel_height;
    logic [3:0] kernel_width;
    logic [3:0] stride_height;
    logic [3:0] stride_width;
    logic [2:0] pad_top;
    logic [2:0] pad_bottom;
    logic [2:0] pad_left;
    logic [2:0] pad_right;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kernel_height: 4'd2, kernel_width: 4'd2,
    stride_height: 4'd2, stride_width: 4'd2,
    pad_top: 3'd0, pad_bottom: 3'd0, pad_left: 3'd0, pad_right: 3'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SIZE,
    ST_WALK,
    ST_FLUSH_A,
    ST_FLUSH_B,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // store one sample
    logic fetch;     // start a window walk
    logic reply;     // answer a fetch with no output available
    logic div_init;  // set up the output-size dividers
    logic div_step;  // one quotient bit per lane
    logic size_set;  // latch output sizes or drop the plane
    logic issue;     // one window position into the read pipeline
    logic emit;      // register the pooled result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emitting;
    logic div_last;
    logic walk_last;
  } dp_status_t;

  function automatic logic [3:0] at_least_one(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

endpackage

/* sv/mp2d_cfg.sv */
// Configuration register file behind an APB-style port.
// Depends on mp2d_pkg for the register layout and reset values.
`timescale 1ns / 1ps

module mp2d_cfg import mp2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KERNEL_H: cfg_r.kernel_height <= pwdata[3:0];
        REG_KERNEL_W: cfg_r.kernel_width  <= pwdata[3:0];
        REG_STRIDE_H: cfg_r.stride_height <= pwdata[3:0];
        REG_STRIDE_W: cfg_r.stride_width  <= pwdata[3:0];
        REG_PAD_TOP:  cfg_r.pad_top       <= pwdata[2:0];
        REG_PAD_BOT:  cfg_r.pad_bottom    <= pwdata[2:0];
        REG_PAD_LEFT: cfg_r.pad_left      <= pwdata[2:0];
        REG_PAD_RGT:  cfg_r.pad_right     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KERNEL_H: prdata = APB_DATA_W'(cfg_r.kernel_height);
      REG_KERNEL_W: prdata = APB_DATA_W'(cfg_r.kernel_width);
      REG_STRIDE_H: prdata = APB_DATA_W'(cfg_r.stride_height);
      REG_STRIDE_W: prdata = APB_DATA_W'(cfg_r.stride_width);
      REG_PAD_TOP:  prdata = APB_DATA_W'(cfg_r.pad_top);
      REG_PAD_BOT:  prdata = APB_DATA_W'(cfg_r.pad_bottom);
      REG_PAD_LEFT: prdata = APB_DATA_W'(cfg_r.pad_left);
      REG_PAD_RGT:  prdata = APB_DATA_W'(cfg_r.pad_right);
      default:      prdata = '0;
    endcase
  end

endmodule

/* sv/mp2d_ctrl.sv */
// Sequencing state machine: accepts commands, steps the dividers and window walk.
// Depends on mp2d_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module mp2d_ctrl import mp2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_action,
  input  logic       in_plane_end,
  input  dp_status_t status,
  output logic       busy,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action == ACT_LOAD) begin
            cmd.load = 1'b1;
            if (in_plane_end) state_nxt = ST_PREP;
          end else if (status.emitting) begin
            cmd.fetch = 1'b1;
            state_nxt = ST_WALK;
          end else begin
            cmd.reply = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_SIZE;
      end
      ST_SIZE: begin
        cmd.size_set = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (status.walk_last) state_nxt = ST_FLUSH_A;
      end
      // flush states let the store read and the final compare finish
      ST_FLUSH_A: state_nxt = ST_FLUSH_B;
      ST_FLUSH_B: state_nxt = ST_EMIT;
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_walk_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> status.emitting)
    else $error("window walk without a latched plane");

  a_fetch_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && in_action == ACT_FETCH && status.emitting)
      |=> (state_r == ST_WALK))
    else $error("accepted fetch did not start a walk");
`endif

endmodule

/* sv/mp2d_datapath.sv */
// Datapath: plane store, load counters, output-size dividers, window walk and result.
// Depends on mp2d_pkg; driven by mp2d_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module mp2d_datapath import mp2d_pkg::*; #(
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_row_end,
  input  logic                          in_plane_end,
  output dp_status_t                    status,
  output logic signed [SAMPLE_BITS-1:0] out_max_value,
  output logic                          out_window_empty,
  output logic                          out_last_output,
  output logic                          out_status,
  output logic                          out_strobe
);

  localparam int MAX_DIM = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  // padded size is at most MAX_DIM + 14
  localparam int DIV_W   = $clog2(MAX_DIM + 15);
  localparam int POS_W   = DIV_W + 5;
  localparam int AW      = (2 * DIM_W + 1 > ADDR_W) ? 2 * DIM_W + 1 : ADDR_W;
  localparam int DC_W    = $clog2(DIV_W + 1);
  localparam logic signed [SAMPLE_BITS-1:0] EMPTY_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [3:0] kh, kw, sh, sw;
  assign kh = at_least_one(cfg.kernel_height);
  assign kw = at_least_one(cfg.kernel_width);
  assign sh = at_least_one(cfg.stride_height);
  assign sw = at_least_one(cfg.stride_width);

  // ---------------- plane bookkeeping ----------------
  logic             emitting_r;
  logic [ADDR_W-1:0] wp_r, wp_eff;
  logic [CNT_W-1:0] cnt_r, cnt_eff, cnt_nxt;
  logic [DIM_W-1:0] width_r, width_eff, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  // running quotient/remainder of the load count by MAX_WIDTH and by the plane width
  logic [CNT_W-1:0] qm_r, qm_eff, qm_nxt, q_r, q_eff, q_nxt;
  logic [DIM_W-1:0] rm_r, rm_eff, rm_nxt, r_r, r_eff, r_nxt;
  logic             cnt_inc, width_over;

  always_comb begin
    // a load while emitting drops the current plane first
    wp_eff    = emitting_r ? '0 : wp_r;
    cnt_eff   = emitting_r ? '0 : cnt_r;
    width_eff = emitting_r ? '0 : width_r;
    qm_eff    = emitting_r ? '0 : qm_r;
    rm_eff    = emitting_r ? '0 : rm_r;
    q_eff     = emitting_r ? '0 : q_r;
    r_eff     = emitting_r ? '0 : r_r;

    cnt_inc = (cnt_eff != CNT_W'(STORE_DEPTH));
    cnt_nxt = cnt_eff + CNT_W'(cnt_inc);

    qm_nxt = qm_eff;
    rm_nxt = rm_eff;
    if (cnt_inc) begin
      if (rm_eff == DIM_W'(MAX_WIDTH - 1)) begin
        rm_nxt = '0;
        qm_nxt = qm_eff + CNT_W'(1);
      end else begin
        rm_nxt = rm_eff + DIM_W'(1);
      end
    end

    width_over = (cnt_nxt > CNT_W'(MAX_WIDTH));
    width_nxt  = width_eff;
    q_nxt      = q_eff;
    r_nxt      = r_eff;
    if (width_eff == '0) begin
      if (in_row_end || in_plane_end) begin
        if (width_over) begin
          width_nxt = DIM_W'(MAX_WIDTH);
          q_nxt     = qm_nxt;
          r_nxt     = rm_nxt;
        end else begin
          width_nxt = cnt_nxt[DIM_W-1:0];
          q_nxt     = CNT_W'(1);
          r_nxt     = '0;
        end
      end
    end else if (cnt_inc) begin
      if (r_eff == width_eff - DIM_W'(1)) begin
        r_nxt = '0;
        q_nxt = q_eff + CNT_W'(1);
      end else begin
        r_nxt = r_eff + DIM_W'(1);
      end
    end

    height_nxt = (q_nxt > CNT_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : q_nxt[DIM_W-1:0];
  end

  // ---------------- output-size dividers, lane 0 rows, lane 1 columns ----------------
  logic [DIV_W-1:0] lane_size [2];
  logic [DIV_W-1:0] lane_pad  [2];
  logic [3:0]       lane_k    [2];
  logic [3:0]       lane_s    [2];
  logic [DIV_W-1:0] padded    [2];
  logic             under_init[2];
  logic [DIV_W-1:0] num_init  [2];
  logic [4:0]       rem_t     [2];
  logic [4:0]       rem_diff  [2];
  logic             ge        [2];
  logic [3:0]       rem_step  [2];
  logic [DIV_W-1:0] num_step  [2];
  logic [DIV_W-1:0] osize     [2];
  logic [DIV_W-1:0] num_r     [2];
  logic [3:0]       rem_r     [2];
  logic             under_r   [2];
  logic [DC_W-1:0]  div_cnt_r;
  logic             size_zero;

  always_comb begin
    lane_size[0] = DIV_W'(height_r);
    lane_size[1] = DIV_W'(width_r);
    lane_pad[0]  = DIV_W'(cfg.pad_top) + DIV_W'(cfg.pad_bottom);
    lane_pad[1]  = DIV_W'(cfg.pad_left) + DIV_W'(cfg.pad_right);
    lane_k[0]    = kh;
    lane_k[1]    = kw;
    lane_s[0]    = sh;
    lane_s[1]    = sw;
    for (int i = 0; i < 2; i++) begin
      padded[i]     = lane_size[i] + lane_pad[i];
      under_init[i] = (padded[i] < DIV_W'(lane_k[i]));
      num_init[i]   = padded[i] - DIV_W'(lane_k[i]);
      rem_t[i]      = {rem_r[i], num_r[i][DIV_W-1]};
      rem_diff[i]   = rem_t[i] - {1'b0, lane_s[i]};
      ge[i]         = (rem_t[i] >= {1'b0, lane_s[i]});
      rem_step[i]   = ge[i] ? rem_diff[i][3:0] : rem_t[i][3:0];
      num_step[i]   = {num_r[i][DIV_W-2:0], ge[i]};
      osize[i]      = under_r[i] ? '0 : num_r[i] + DIV_W'(1);
    end
    size_zero = (osize[0] == '0) || (osize[1] == '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (cmd.div_init) begin
        num_r[i]   <= num_init[i];
        rem_r[i]   <= '0;
        under_r[i] <= under_init[i];
      end else if (cmd.div_step) begin
        num_r[i] <= num_step[i];
        rem_r[i] <= rem_step[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_init) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DC_W'(1);
    end
  end

  // ---------------- output position ----------------
  logic [DIV_W-1:0] out_row_r, out_col_r, out_h_r, out_w_r;
  logic [DIV_W:0]   row_plus, col_plus;
  logic             last_out, plane_clear;

  assign row_plus    = {1'b0, out_row_r} + (DIV_W+1)'(1);
  assign col_plus    = {1'b0, out_col_r} + (DIV_W+1)'(1);
  assign last_out    = (row_plus == {1'b0, out_h_r}) && (col_plus == {1'b0, out_w_r});
  assign plane_clear = (cmd.size_set && size_zero) || (cmd.emit && last_out);

  always_ff @(posedge clk) begin
    if (!rst_n || plane_clear) begin
      emitting_r <= 1'b0;
      wp_r       <= '0;
      cnt_r      <= '0;
      width_r    <= '0;
      height_r   <= '0;
      qm_r       <= '0;
      rm_r       <= '0;
      q_r        <= '0;
      r_r        <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_h_r    <= '0;
      out_w_r    <= '0;
    end else begin
      if (cmd.load) begin
        emitting_r <= 1'b0;
        wp_r       <= wp_eff + ADDR_W'(1);
        cnt_r      <= cnt_nxt;
        width_r    <= width_nxt;
        height_r   <= in_plane_end ? height_nxt : '0;
        qm_r       <= qm_nxt;
        rm_r       <= rm_nxt;
        q_r        <= q_nxt;
        r_r        <= r_nxt;
        out_row_r  <= '0;
        out_col_r  <= '0;
      end
      if (cmd.size_set) begin
        emitting_r <= 1'b1;
        out_h_r    <= osize[0];
        out_w_r    <= osize[1];
        out_row_r  <= '0;
        out_col_r  <= '0;
      end
      if (cmd.emit) begin
        if (col_plus == {1'b0, out_w_r}) begin
          out_col_r <= '0;
          out_row_r <= row_plus[DIV_W-1:0];
        end else begin
          out_col_r <= col_plus[DIV_W-1:0];
        end
      end
    end
  end

  // ---------------- plane store ----------------
  logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
  logic [ADDR_W-1:0]      addr_r;
  logic signed [SAMPLE_BITS-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_mem[wp_eff] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= store_mem[addr_r];
  end

  // ---------------- window walk ----------------
  logic [POS_W-1:0] base_row_r, base_col_r;
  logic [3:0]       kr_r, kc_r;
  logic [POS_W-1:0] ph, pw, iy, ix;
  logic             row_ok, col_ok;
  logic [AW-1:0]    lin_addr;
  logic             v1_r, v2_r, found_r;
  logic signed [SAMPLE_BITS-1:0] best_r;

  always_comb begin
    ph       = base_row_r + POS_W'(kr_r);
    pw       = base_col_r + POS_W'(kc_r);
    iy       = ph - POS_W'(cfg.pad_top);
    ix       = pw - POS_W'(cfg.pad_left);
    row_ok   = (ph >= POS_W'(cfg.pad_top)) && (iy < POS_W'(height_r));
    col_ok   = (pw >= POS_W'(cfg.pad_left)) && (ix < POS_W'(width_r));
    lin_addr = AW'(iy[DIM_W-1:0]) * AW'(width_r) + AW'(ix[DIM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      base_row_r <= POS_W'(out_row_r) * POS_W'(sh);
      base_col_r <= POS_W'(out_col_r) * POS_W'(sw);
    end
    if (cmd.issue) begin
      addr_r <= lin_addr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kr_r    <= '0;
      kc_r    <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue && row_ok && col_ok;
      v2_r <= v1_r;
      if (v2_r) found_r <= 1'b1;
      if (cmd.fetch) begin
        kr_r    <= '0;
        kc_r    <= '0;
        found_r <= 1'b0;
      end else if (cmd.issue) begin
        if (kc_r == kw - 4'd1) begin
          kc_r <= '0;
          kr_r <= kr_r + 4'd1;
        end else begin
          kc_r <= kc_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      best_r <= EMPTY_VAL;
    end else if (v2_r && (!found_r || rd_r > best_r)) begin
      best_r <= rd_r;
    end
  end

  assign status.emitting  = emitting_r;
  assign status.div_last  = (div_cnt_r == DC_W'(DIV_W - 1));
  assign status.walk_last = (kr_r == kh - 4'd1) && (kc_r == kw - 4'd1);

  // ---------------- result register ----------------
  logic                          out_strobe_r;
  logic signed [SAMPLE_BITS-1:0] out_max_value_r;
  logic                          out_window_empty_r, out_last_output_r, out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit || cmd.reply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_max_value_r    <= best_r;
      out_window_empty_r <= !found_r;
      out_last_output_r  <= last_out;
      out_status_r       <= STATUS_OK;
    end else if (cmd.reply) begin
      out_max_value_r    <= '0;
      out_window_empty_r <= 1'b0;
      out_last_output_r  <= 1'b0;
      out_status_r       <= STATUS_NONE;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_max_value    = out_max_value_r;
  assign out_window_empty = out_window_empty_r;
  assign out_last_output  = out_last_output_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_strobe_r)
    else $error("pooled result not presented after emit");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_window_empty_r) |-> (out_max_value_r == EMPTY_VAL))
    else $error("empty window with a value other than the most negative sample");
`endif

endmodule

/* sv/max_pool_2d_padded.sv */
// Top level of the 2-D max pooling block with padding.
// Depends on mp2d_pkg, mp2d_cfg, mp2d_ctrl and mp2d_datapath.
`timescale 1ns / 1ps

// Usage
//   Command channel: an item is taken when start is high and busy is low.
//   in_action = load stores in_sample in row-major order; in_row_end on the
//   first row fixes the plane width, in_plane_end closes the plane.
//   in_action = fetch returns the next pooled output of the closed plane, or
//   a result with out_status set when no plane is ready.
//   Results: one per fetch, on the out_ ports for one cycle with out_strobe.
//   The receiver cannot stall; every result must be taken when strobed.
//   Registers: eight window registers on the APB port, written while idle.
// Operation
//   Load: busy stays low, but a load with in_plane_end then steps the
//   output-size dividers before busy falls. Fetch: busy through the window
//   walk, one store read per window position, padding positions included,
//   then the flush states; the result strobes in the first cycle with busy
//   low. Fetch with no plane: result the next cycle.
// Reset: synchronous, active low; registers go to 2x2 kernel, stride 2,
//   no padding, and the block waits for the first sample of a new plane.

module max_pool_2d_padded import mp2d_pkg::*; #(
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_row_end,
  input  logic                          in_plane_end,
  // result channel
  output logic                          out_strobe,
  output logic signed [SAMPLE_BITS-1:0] out_max_value,
  output logic                          out_window_empty,
  output logic                          out_last_output,
  output logic                          out_status,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  mp2d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mp2d_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_action    (in_action),
    .in_plane_end (in_plane_end),
    .status       (status),
    .busy         (busy),
    .cmd          (cmd)
  );

  mp2d_datapath #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_sample        (in_sample),
    .in_row_end       (in_row_end),
    .in_plane_end     (in_plane_end),
    .status           (status),
    .out_max_value    (out_max_value),
    .out_window_empty (out_window_empty),
    .out_last_output  (out_last_output),
    .out_status       (out_status),
    .out_strobe       (out_strobe)
  );

endmodule
